FILE: hw/rtl/rc4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the RC4 byte engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W                = 8;
    localparam int SBOX_DEPTH            = 256;
    localparam int SBOX_ADDR_W           = 8;
    localparam int CFG_IDX_W             = 2;
    localparam int CFG_DATA_W            = 64;
    localparam int KEY_LEN_W             = 5;
    localparam int DEFAULT_MAX_KEY_BYTES = 16;
    localparam int LOW_KEY_BYTES         = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET  = 5'd16;

    typedef struct packed {
        logic start;
        logic out_free;
    } rc4_ctrl_t;

    typedef struct packed {
        logic idle;
        logic out_load;
    } rc4_stat_t;

endpackage

FILE: hw/rtl/rc4_stream_cipher_core.sv
`timescale 1ns / 1ps
// The core takes no new word until it is through with the last one: the
// permutation table has a single read port and a single write port, so the two
// reads, the two swap writes and the keystream read follow one another under
// the sequencer. The first word after reset, and the first word after a word
// marked last of message, additionally runs the key schedule: it loads the
// identity permutation, then runs one schedule step for each table entry.
// The finished word sits in an output register, so a stalled consumer only
// holds the engine once a second result is ready.
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 byte engine: each input word is XORed with the next keystream byte. Key
// bytes and key length are held in configuration registers.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core #(
    parameter int MAX_KEY_BYTES = rc4_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rc4_pkg::BYTE_W-1:0]       s_data_in,
    input  logic                             s_last_of_message,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rc4_pkg::BYTE_W-1:0]       m_data_out
);

    import rc4_pkg::*;

    logic [MAX_KEY_BYTES-1:0][BYTE_W-1:0] key_reg;
    logic [KEY_LEN_W-1:0]                 key_length_reg;
    logic                                 m_valid_reg;
    logic [BYTE_W-1:0]                    m_data_reg;

    logic                                 cfg_write;
    rc4_ctrl_t                            ctrl;
    rc4_stat_t                            stat;
    logic [BYTE_W-1:0]                    engine_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg        <= '0;
            key_length_reg <= KEY_LEN_RESET;
        end else if (cfg_write) begin
            for (int n = 0; n < MAX_KEY_BYTES; n++) begin
                if ((n < LOW_KEY_BYTES) && (cfg_index == REG_KEY_LOW)) begin
                    key_reg[n] <= cfg_data[BYTE_W*(n & 7) +: BYTE_W];
                end
                if ((n >= LOW_KEY_BYTES) && (cfg_index == REG_KEY_HIGH)) begin
                    key_reg[n] <= cfg_data[BYTE_W*(n & 7) +: BYTE_W];
                end
            end
            if (cfg_index == REG_KEY_LENGTH) begin
                key_length_reg <= cfg_data[KEY_LEN_W-1:0];
            end
        end
    end

    assign s_ready       = stat.idle;
    assign ctrl.start    = s_valid && s_ready;
    assign ctrl.out_free = !m_valid_reg || m_ready;

    rc4_engine #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .data_in    (s_data_in),
        .last_in    (s_last_of_message),
        .key_bytes  (key_reg),
        .key_length (key_length_reg),
        .data_out   (engine_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (stat.out_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= engine_data;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;

endmodule

FILE: hw/rtl/rc4_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/rc4_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_engine
// Sequencer around one shared byte adder and the permutation table. Runs the
// key schedule when a rekey is pending, then produces one keystream byte.
// ----------------------------------------------------------------------------
module rc4_engine #(
    parameter int MAX_KEY_BYTES = rc4_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  rc4_pkg::rc4_ctrl_t                            ctrl,
    output rc4_pkg::rc4_stat_t                            stat,
    input  logic [rc4_pkg::BYTE_W-1:0]                    data_in,
    input  logic                                          last_in,
    input  logic [MAX_KEY_BYTES-1:0][rc4_pkg::BYTE_W-1:0] key_bytes,
    input  logic [rc4_pkg::KEY_LEN_W-1:0]                 key_length,
    output logic [rc4_pkg::BYTE_W-1:0]                    data_out
);

    import rc4_pkg::*;

    localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);
    localparam logic [SBOX_ADDR_W-1:0] LAST_ADDR = SBOX_ADDR_W'(SBOX_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        KS_RD_I,
        KS_ADD,
        KS_RD_J,
        KS_WR_I,
        KS_WR_J,
        PR_INC,
        PR_RD_I,
        PR_ADD,
        PR_RD_J,
        PR_WR_I,
        PR_WR_J,
        PR_RD_T,
        PR_OUT
    } state_t;

    state_t                 state_reg;
    logic [SBOX_ADDR_W-1:0] k_reg;
    logic [SBOX_ADDR_W-1:0] i_reg;
    logic [SBOX_ADDR_W-1:0] j_reg;
    logic [BYTE_W-1:0]      t_reg;
    logic [BYTE_W-1:0]      s_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [BYTE_W-1:0]      data_reg;
    logic                   last_reg;
    logic                   rekey_reg;

    logic [BYTE_W-1:0]      add_a;
    logic [BYTE_W-1:0]      add_b;
    logic [BYTE_W-1:0]      add_c;
    logic [BYTE_W-1:0]      sum;

    logic [KEY_LEN_W-1:0]   len_eff;
    logic [KEY_LEN_W-1:0]   pos_inc;
    logic [POS_W-1:0]       pos_next;

    logic                   ram_we;
    logic [SBOX_ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0]      ram_wdata;
    logic [SBOX_ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0]      ram_rdata;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Zero-length keys use one byte; longer keys saturate at the storage size.
    always_comb begin
        if (key_length == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (key_length > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = key_length;
        end
        pos_inc  = KEY_LEN_W'(pos_reg) + KEY_LEN_W'(1);
        pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
    end

    always_comb begin
        add_a = '0;
        add_b = '0;
        add_c = '0;
        unique case (state_reg)
            ST_FILL, KS_WR_J: begin
                add_a = k_reg;
                add_c = BYTE_W'(1);
            end
            KS_ADD: begin
                add_a = j_reg;
                add_b = ram_rdata;
                add_c = key_bytes[pos_reg];
            end
            PR_INC: begin
                add_a = i_reg;
                add_c = BYTE_W'(1);
            end
            PR_ADD: begin
                add_a = j_reg;
                add_b = ram_rdata;
            end
            PR_WR_I: begin
                add_a = t_reg;
                add_b = ram_rdata;
            end
            default: begin
                add_a = '0;
            end
        endcase
        sum = add_a + add_b + add_c;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = k_reg;
        ram_wdata = ram_rdata;
        ram_raddr = k_reg;
        unique case (state_reg)
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = k_reg;
            end
            KS_RD_J, PR_RD_J: begin
                ram_raddr = j_reg;
            end
            KS_WR_I: begin
                ram_we = 1'b1;
            end
            KS_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = t_reg;
            end
            PR_RD_I: begin
                ram_raddr = i_reg;
            end
            PR_WR_I: begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
            end
            PR_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = t_reg;
            end
            PR_RD_T, PR_OUT: begin
                ram_raddr = s_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign stat.idle     = (state_reg == ST_IDLE);
    assign stat.out_load = (state_reg == PR_OUT) && ctrl.out_free;
    assign data_out      = data_reg ^ ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            pos_reg   <= '0;
            rekey_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (ctrl.start) begin
                        data_reg <= data_in;
                        last_reg <= last_in;
                        k_reg    <= '0;
                        if (rekey_reg) begin
                            state_reg <= ST_FILL;
                        end else begin
                            state_reg <= PR_INC;
                        end
                    end
                end
                ST_FILL: begin
                    k_reg <= sum;
                    if (k_reg == LAST_ADDR) begin
                        j_reg     <= '0;
                        pos_reg   <= '0;
                        state_reg <= KS_RD_I;
                    end
                end
                KS_RD_I: begin
                    state_reg <= KS_ADD;
                end
                KS_ADD: begin
                    t_reg     <= ram_rdata;
                    j_reg     <= sum;
                    pos_reg   <= pos_next;
                    state_reg <= KS_RD_J;
                end
                KS_RD_J: begin
                    state_reg <= KS_WR_I;
                end
                KS_WR_I: begin
                    state_reg <= KS_WR_J;
                end
                KS_WR_J: begin
                    k_reg <= sum;
                    if (k_reg == LAST_ADDR) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        rekey_reg <= 1'b0;
                        state_reg <= PR_INC;
                    end else begin
                        state_reg <= KS_RD_I;
                    end
                end
                PR_INC: begin
                    i_reg     <= sum;
                    state_reg <= PR_RD_I;
                end
                PR_RD_I: begin
                    state_reg <= PR_ADD;
                end
                PR_ADD: begin
                    t_reg     <= ram_rdata;
                    j_reg     <= sum;
                    state_reg <= PR_RD_J;
                end
                PR_RD_J: begin
                    state_reg <= PR_WR_I;
                end
                PR_WR_I: begin
                    s_reg     <= sum;
                    state_reg <= PR_WR_J;
                end
                PR_WR_J: begin
                    state_reg <= PR_RD_T;
                end
                PR_RD_T: begin
                    state_reg <= PR_OUT;
                end
                PR_OUT: begin
                    if (ctrl.out_free) begin
                        rekey_reg <= last_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RC4 byte engine. A directed table covers
// published test vectors, key length extremes, an ignored register index and a
// key change in the middle of a message. A long random run of messages with
// random keys follows. Every output word is checked against the published
// value where the table gives one, else against an RC4 model in the bench.
// ----------------------------------------------------------------------------
module tb_top;

    import rc4_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int WORD_TARGET = 1350;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        logic [BYTE_W-1:0]     din;
        logic                  last;
        logic                  known;
        logic [BYTE_W-1:0]     known_out;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data_in;
    logic                  s_last_of_message;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BYTE_W-1:0]     m_data_out;

    logic [CFG_DATA_W-1:0] key_lo_q;
    logic [CFG_DATA_W-1:0] key_hi_q;
    logic [KEY_LEN_W-1:0]  key_len_q;
    logic [BYTE_W-1:0]     sbox [0:SBOX_DEPTH-1];
    logic [BYTE_W-1:0]     ks_i;
    logic [BYTE_W-1:0]     ks_j;
    logic                  rekey_due;

    logic [BYTE_W-1:0]     cipher_q [$];
    logic [BYTE_W-1:0]     want_byte;
    dir_row_t              dir_table [0:34];
    int                    fail_count = 0;
    int                    words_sent = 0;
    int                    stall_left = 0;
    logic                  calm = 1'b0;

    rc4_stream_cipher_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_in         (s_data_in),
        .s_last_of_message (s_last_of_message),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data_out        (m_data_out)
    );

    always #6 aclk = ~aclk;

    function automatic void schedule_key();
        int klen;
        int pos;
        int k;
        logic [BYTE_W-1:0] j;
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] kb;
        klen = key_len_q;
        if (klen == 0) klen = 1;
        if (klen > DEFAULT_MAX_KEY_BYTES) klen = DEFAULT_MAX_KEY_BYTES;
        for (k = 0; k < SBOX_DEPTH; k++) sbox[k] = 8'(k);
        j = '0;
        pos = 0;
        for (k = 0; k < SBOX_DEPTH; k++) begin
            t = sbox[k];
            if (pos < LOW_KEY_BYTES) kb = key_lo_q[pos*8 +: 8];
            else kb = key_hi_q[(pos-LOW_KEY_BYTES)*8 +: 8];
            j = j + t + kb;
            pos++;
            if (pos >= klen) pos = 0;
            sbox[k] = sbox[j];
            sbox[j] = t;
        end
        ks_i = '0;
        ks_j = '0;
    endfunction

    function automatic logic [BYTE_W-1:0] cipher_byte(input logic [BYTE_W-1:0] din,
                                                      input logic last);
        logic [BYTE_W-1:0] ti;
        logic [BYTE_W-1:0] tj;
        if (rekey_due) schedule_key();
        ks_i = ks_i + 8'd1;
        ti = sbox[ks_i];
        ks_j = ks_j + ti;
        tj = sbox[ks_j];
        sbox[ks_i] = tj;
        sbox[ks_j] = ti;
        rekey_due = last;
        return din ^ sbox[8'(ti + tj)];
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_KEY_LOW:    key_lo_q = value;
            REG_KEY_HIGH:   key_hi_q = value;
            REG_KEY_LENGTH: key_len_q = value[KEY_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_random_reg();
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        idx = CFG_IDX_W'($urandom_range(0, 3));
        value = {$urandom(), $urandom()};
        if (idx == REG_KEY_LENGTH) begin
            case ($urandom_range(0, 5))
                0: value[KEY_LEN_W-1:0] = 5'd0;
                1: value[KEY_LEN_W-1:0] = 5'd1;
                2: value[KEY_LEN_W-1:0] = 5'd16;
                3: value[KEY_LEN_W-1:0] = 5'd31;
                default: value[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(1, 16));
            endcase
        end
        write_reg(idx, value);
    endtask

    task automatic send_word(input logic [BYTE_W-1:0] din, input logic last,
                             input logic known, input logic [BYTE_W-1:0] known_out);
        logic [BYTE_W-1:0] predicted;
        int gap;
        cfg_valid <= 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data_in         <= din;
        s_last_of_message <= last;
        do @(posedge aclk); while (!s_ready);
        predicted = cipher_byte(din, last);
        cipher_q.push_back(known ? known_out : predicted);
        words_sent++;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 59) == 0) begin
            stall_left <= $urandom_range(1, 11);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %02h",
                         $time, m_data_out);
                fail_count++;
            end else begin
                want_byte = cipher_q.pop_front();
                if (m_data_out !== want_byte) begin
                    $display("%0t: data_out mismatch, expected %02h, actual %02h",
                             $time, want_byte, m_data_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #(200_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int msg_len;
        int k;
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        s_valid           = 1'b0;
        s_data_in         = '0;
        s_last_of_message = 1'b0;
        key_lo_q          = '0;
        key_hi_q          = '0;
        key_len_q         = KEY_LEN_RESET;
        rekey_due         = 1'b1;
        ks_i              = '0;
        ks_j              = '0;
        for (k = 0; k < SBOX_DEPTH; k++) sbox[k] = 8'(k);

        // The two published vectors use the keys "Key" and "Wiki".
        dir_table = '{
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h00, 1'b1, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LOW,    64'h0000_0000_0079_654B, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LENGTH, 64'd3,                   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h50, 1'b0, 1'b1, 8'hBB},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h6C, 1'b0, 1'b1, 8'hF3},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h61, 1'b0, 1'b1, 8'h16},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h69, 1'b0, 1'b1, 8'hE8},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h6E, 1'b0, 1'b1, 8'hD9},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h74, 1'b0, 1'b1, 8'h40},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h65, 1'b0, 1'b1, 8'hAF},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h78, 1'b0, 1'b1, 8'h0A},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h74, 1'b1, 1'b1, 8'hD3},
            '{ROW_REG,  REG_KEY_LOW,    64'h0000_0000_696B_6957, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LENGTH, 64'd4,                   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h70, 1'b0, 1'b1, 8'h10},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h65, 1'b0, 1'b1, 8'h21},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h64, 1'b0, 1'b1, 8'hBF},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h69, 1'b0, 1'b1, 8'h04},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h61, 1'b1, 1'b1, 8'h20},
            '{ROW_REG,  REG_NONE,       64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LENGTH, 64'd0,                   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_HIGH,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LOW,    64'h0,                   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LOW,    64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_HIGH,   64'h0,                   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h80, 1'b0, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LOW,    64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h7F, 1'b1, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h01, 1'b1, 1'b0, 8'h00},
            '{ROW_REG,  REG_KEY_LENGTH, 64'd16,                  8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WORD, REG_KEY_LOW,    64'h0,                   8'h5A, 1'b1, 1'b0, 8'h00}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_REG) begin
                wait_drained();
                write_reg(dir_table[r].idx, dir_table[r].value);
            end else begin
                send_word(dir_table[r].din, dir_table[r].last,
                          dir_table[r].known, dir_table[r].known_out);
            end
        end

        // Messages are mostly short, so the key schedule runs often.
        while (words_sent < WORD_TARGET) begin
            calm = (words_sent >= 500 && words_sent < 760);
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                repeat ($urandom_range(1, 3)) write_random_reg();
            end
            if ($urandom_range(0, 9) == 0) msg_len = $urandom_range(30, 90);
            else msg_len = $urandom_range(1, 12);
            for (k = 0; k < msg_len; k++) begin
                if (k > 0 && $urandom_range(0, 39) == 0) begin
                    wait_drained();
                    write_random_reg();
                end
                send_word(BYTE_W'($urandom_range(0, 255)), k == msg_len - 1,
                          1'b0, 8'h00);
            end
        end

        calm = 1'b0;
        cfg_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
